// ----- rtl/core/mhpq_pkg.sv -----
// Shared types and constants for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    typedef logic signed [31:0] t_key;

    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_EXTRACT  = 2'd1,
        MODE_DECREASE = 2'd2,
        MODE_DELETE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Operand selection for the shared key comparator.
    typedef enum logic [1:0] {
        CMP_UP    = 2'd0,
        CMP_LEFT  = 2'd1,
        CMP_RIGHT = 2'd2
    } t_cmp_sel;

    typedef struct packed {
        t_mode      mode;
        t_key       key;
        logic [5:0] position;
    } t_in_word;

    typedef struct packed {
        t_key       removed_key;
        t_status    status;
        logic [6:0] entry_count;
    } t_out_word;

endpackage

// ----- rtl/core/mhpq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mhpq_cmp.sv -----
// Shared signed key comparator with operand selection for sift up and sift down.
`timescale 1ns / 1ps

module mhpq_cmp (
    input  mhpq_pkg::t_cmp_sel i_sel,
    input  mhpq_pkg::t_key     i_walk_key,
    input  mhpq_pkg::t_key     i_best_key,
    input  mhpq_pkg::t_key     i_rd_key,
    output logic               o_less
);

    mhpq_pkg::t_key op_a;
    mhpq_pkg::t_key op_b;

    always_comb begin
        case (i_sel)
            mhpq_pkg::CMP_UP: begin
                op_a = i_walk_key;
                op_b = i_rd_key;
            end
            mhpq_pkg::CMP_LEFT: begin
                op_a = i_rd_key;
                op_b = i_walk_key;
            end
            mhpq_pkg::CMP_RIGHT: begin
                op_a = i_rd_key;
                op_b = i_best_key;
            end
            default: begin
                op_a = i_rd_key;
                op_b = i_rd_key;
            end
        endcase
    end

    assign o_less = (op_a < op_b);

endmodule

// ----- rtl/core/min_heap_priority_queue.sv -----
// Top level of the binary min-heap priority queue with a one-write, one-read heap RAM.
// Insert and decrease climb the key level by level toward the root; extract reads the root,
// refills it from the last entry and sinks that entry level by level; delete climbs to the
// root and then extracts; errors go straight to the result. Input is ready again in the
// cycle after the result is loaded. Synchronous active-low reset empties the heap and
// clears the state and output valid only.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mhpq_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mhpq_pkg::t_out_word o_out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;
    localparam int PW = (CW > 6) ? CW : 6;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_UP_RD   = 10'b00_0000_0010,
        S_UP_CMP  = 10'b00_0000_0100,
        S_EX_RD0  = 10'b00_0000_1000,
        S_EX_RDL  = 10'b00_0001_0000,
        S_EX_LAST = 10'b00_0010_0000,
        S_DN_RDL  = 10'b00_0100_0000,
        S_DN_RDR  = 10'b00_1000_0000,
        S_DN_CMP  = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_at, n_at;
    mhpq_pkg::t_key      r_key, n_key;
    mhpq_pkg::t_key      r_best, n_best;
    logic                r_best_left, n_best_left;
    logic                r_del, n_del;
    mhpq_pkg::t_key      r_removed, n_removed;
    mhpq_pkg::t_status   r_status, n_status;
    mhpq_pkg::t_out_word r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    mhpq_pkg::t_key      ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [31:0]         ram_rdata_raw;
    mhpq_pkg::t_key      rd_key;

    mhpq_pkg::t_cmp_sel  cmp_sel;
    logic                cmp_less;

    logic [IW-1:0]       at_m1;
    logic [IW-1:0]       parent_idx;
    logic [LW-1:0]       left_idx;
    logic [LW-1:0]       right_idx;
    logic [LW-1:0]       count_l;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       count_p;
    logic [CW-1:0]       count_m1;
    logic [CW+6:0]       count_wide;

    mhpq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign rd_key = mhpq_pkg::t_key'(ram_rdata_raw);

    mhpq_cmp u_cmp (
        .i_sel      (cmp_sel),
        .i_walk_key (r_key),
        .i_best_key (r_best),
        .i_rd_key   (rd_key),
        .o_less     (cmp_less)
    );

    assign at_m1      = r_at - IW'(1);
    assign parent_idx = at_m1 >> 1;
    assign left_idx   = {1'b0, r_at, 1'b1};
    assign right_idx  = left_idx + LW'(1);
    assign count_l    = LW'(r_count);
    assign pos_ext    = PW'(i_in_data.position);
    assign count_p    = PW'(r_count);
    assign count_m1   = r_count - CW'(1);
    assign count_wide = {7'd0, r_count};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_at        = r_at;
        n_key       = r_key;
        n_best      = r_best;
        n_best_left = r_best_left;
        n_del       = r_del;
        n_removed   = r_removed;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_at;
        ram_wdata   = r_key;
        ram_raddr   = '0;
        cmp_sel     = mhpq_pkg::CMP_UP;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_removed = '0;
                    n_status  = mhpq_pkg::ST_OK;
                    n_del     = 1'b0;
                    case (i_in_data.mode)
                        mhpq_pkg::MODE_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = mhpq_pkg::ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                n_key   = i_in_data.key;
                                n_at    = r_count[IW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        mhpq_pkg::MODE_EXTRACT: begin
                            if (r_count == '0) begin
                                n_removed = mhpq_pkg::KEY_MAX;
                                n_status  = mhpq_pkg::ST_EMPTY;
                                n_state   = S_OUT;
                            end else begin
                                n_state = S_EX_RD0;
                            end
                        end
                        mhpq_pkg::MODE_DECREASE, mhpq_pkg::MODE_DELETE: begin
                            if (pos_ext >= count_p) begin
                                n_status = mhpq_pkg::ST_RANGE;
                                n_state  = S_OUT;
                            end else begin
                                n_at  = pos_ext[IW-1:0];
                                n_del = (i_in_data.mode == mhpq_pkg::MODE_DELETE);
                                n_key = (i_in_data.mode == mhpq_pkg::MODE_DELETE) ?
                                        mhpq_pkg::KEY_MIN : i_in_data.key;
                                n_state = S_UP_RD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            // The walking key is held in a register; parents move down into the hole.
            S_UP_RD: begin
                if (r_at == '0) begin
                    ram_we  = 1'b1;
                    n_state = r_del ? S_EX_RD0 : S_OUT;
                end else begin
                    ram_raddr = parent_idx;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                cmp_sel = mhpq_pkg::CMP_UP;
                ram_we  = 1'b1;
                if (cmp_less) begin
                    ram_wdata = rd_key;
                    n_at      = parent_idx;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = r_del ? S_EX_RD0 : S_OUT;
                end
            end

            S_EX_RD0: begin
                ram_raddr = '0;
                n_state   = S_EX_RDL;
            end

            // The root word arrives here; the last entry is read next and refills the root.
            S_EX_RDL: begin
                if (!r_del) begin
                    n_removed = rd_key;
                end
                ram_raddr = count_m1[IW-1:0];
                n_count   = count_m1;
                n_at      = '0;
                n_state   = S_EX_LAST;
            end

            S_EX_LAST: begin
                n_key   = rd_key;
                n_state = S_DN_RDL;
            end

            S_DN_RDL: begin
                if (left_idx >= count_l) begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    ram_raddr = left_idx[IW-1:0];
                    n_state   = S_DN_RDR;
                end
            end

            S_DN_RDR: begin
                cmp_sel     = mhpq_pkg::CMP_LEFT;
                n_best      = cmp_less ? rd_key : r_key;
                n_best_left = cmp_less;
                if (right_idx < count_l) begin
                    ram_raddr = right_idx[IW-1:0];
                    n_state   = S_DN_CMP;
                end else if (cmp_less) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_key;
                    n_at      = left_idx[IW-1:0];
                    n_state   = S_DN_RDL;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end
            end

            // The right child wins only when strictly below the better of the key and left.
            S_DN_CMP: begin
                cmp_sel = mhpq_pkg::CMP_RIGHT;
                ram_we  = 1'b1;
                if (cmp_less) begin
                    ram_wdata = rd_key;
                    n_at      = right_idx[IW-1:0];
                    n_state   = S_DN_RDL;
                end else if (r_best_left) begin
                    ram_wdata = r_best;
                    n_at      = left_idx[IW-1:0];
                    n_state   = S_DN_RDL;
                end else begin
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.removed_key = r_removed;
                    n_out.status      = r_status;
                    n_out.entry_count = count_wide[6:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_at        <= n_at;
        r_key       <= n_key;
        r_best      <= n_best;
        r_best_left <= n_best_left;
        r_del       <= n_del;
        r_removed   <= n_removed;
        r_status    <= n_status;
        r_out       <= n_out;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD || r_state == S_UP_CMP) |-> (CW'(r_at) < r_count))
        else $error("sift-up index outside the held entries");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + CW'(1)) ||
                           (r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one in a cycle");

endmodule

// ----- sim/tb_min_heap_priority_queue.sv -----
// Self-checking testbench for the min-heap priority queue: directed, fill/drain and random tests.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;

    localparam int CAPACITY    = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mhpq_pkg::t_in_word  in_word;
    logic                out_valid;
    logic                out_ready;
    mhpq_pkg::t_out_word out_word;

    // Software image of the heap, advanced as each word is accepted.
    mhpq_pkg::t_key      heap_mdl [CAPACITY];
    int                  heap_mdl_count;
    mhpq_pkg::t_out_word pending_results [$];

    int  errors;
    int  words_sent;
    int  results_checked;
    int  mode_seen [4];
    int  status_seen [4];
    bit  tx_steady;
    bit  rx_steady;
    bit  hold_off_req;

    min_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_word)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_min_heap_priority_queue NOT OK");
        $finish;
    end

    function automatic void heap_swap(int a, int b);
        mhpq_pkg::t_key t;
        t = heap_mdl[a];
        heap_mdl[a] = heap_mdl[b];
        heap_mdl[b] = t;
    endfunction

    function automatic void heap_climb(int at);
        int up;
        while (at > 0) begin
            up = (at - 1) / 2;
            if (!(heap_mdl[at] < heap_mdl[up]))
                break;
            heap_swap(at, up);
            at = up;
        end
    endfunction

    // Moves the last entry to the root and sinks it; returns the old minimum.
    function automatic mhpq_pkg::t_key heap_take_min();
        int last;
        int at;
        int l;
        int r;
        int best;
        last = heap_mdl_count - 1;
        heap_swap(0, last);
        heap_mdl_count = last;
        at = 0;
        forever begin
            l = 2 * at + 1;
            r = l + 1;
            best = at;
            if (l < heap_mdl_count && heap_mdl[l] < heap_mdl[best])
                best = l;
            if (r < heap_mdl_count && heap_mdl[r] < heap_mdl[best])
                best = r;
            if (best == at)
                break;
            heap_swap(at, best);
            at = best;
        end
        return heap_mdl[last];
    endfunction

    function automatic mhpq_pkg::t_out_word heap_apply(mhpq_pkg::t_in_word w);
        mhpq_pkg::t_out_word res;
        res.removed_key = '0;
        res.status = mhpq_pkg::ST_OK;
        case (w.mode)
            mhpq_pkg::MODE_INSERT: begin
                if (heap_mdl_count >= CAPACITY) begin
                    res.status = mhpq_pkg::ST_FULL;
                end else begin
                    heap_mdl[heap_mdl_count] = w.key;
                    heap_mdl_count++;
                    heap_climb(heap_mdl_count - 1);
                end
            end
            mhpq_pkg::MODE_EXTRACT: begin
                if (heap_mdl_count == 0) begin
                    res.removed_key = mhpq_pkg::KEY_MAX;
                    res.status = mhpq_pkg::ST_EMPTY;
                end else begin
                    res.removed_key = heap_take_min();
                end
            end
            default: begin
                if (int'(w.position) >= heap_mdl_count) begin
                    res.status = mhpq_pkg::ST_RANGE;
                end else if (w.mode == mhpq_pkg::MODE_DECREASE) begin
                    // The new key only climbs, even when it is larger.
                    heap_mdl[w.position] = w.key;
                    heap_climb(int'(w.position));
                end else begin
                    heap_mdl[w.position] = mhpq_pkg::KEY_MIN;
                    heap_climb(int'(w.position));
                    void'(heap_take_min());
                end
            end
        endcase
        res.entry_count = 7'(heap_mdl_count);
        mode_seen[w.mode]++;
        status_seen[res.status]++;
        return res;
    endfunction

    function automatic mhpq_pkg::t_in_word word_of(mhpq_pkg::t_mode m, mhpq_pkg::t_key k,
                                                   logic [5:0] p);
        mhpq_pkg::t_in_word w;
        w.mode = m;
        w.key = k;
        w.position = p;
        return w;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic mhpq_pkg::t_key rand_key();
        int roll;
        mhpq_pkg::t_key k;
        roll = $urandom_range(99);
        if (roll < 8)
            return mhpq_pkg::KEY_MIN;
        if (roll < 16)
            return mhpq_pkg::KEY_MAX;
        if (roll < 45) begin
            k = $urandom_range(16);
            return k - 8;
        end
        return $urandom;
    endfunction

    function automatic logic [5:0] rand_position();
        if (heap_mdl_count > 0 && $urandom_range(99) < 85)
            return 6'($urandom_range(heap_mdl_count - 1));
        return 6'($urandom_range(63));
    endfunction

    // Offers one word, predicts its result on acceptance, then sometimes idles a while.
    task automatic send_word(input mhpq_pkg::t_in_word w);
        int gap;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        pending_results.push_back(heap_apply(w));
        words_sent++;
        gap = 0;
        if (!tx_steady && $urandom_range(99) < 50)
            gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Receiver: random stalls, steady stretches, and one long hold-off on request.
    initial begin : rx_side
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (rx_steady || $urandom_range(99) < 75) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : result_check
        mhpq_pkg::t_out_word exp_w;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %p", $time, out_word);
                errors++;
            end else begin
                exp_w = pending_results.pop_front();
                results_checked++;
                if (out_word.removed_key !== exp_w.removed_key) begin
                    $display("%0t: removed_key expected %0d, got %0d",
                             $time, exp_w.removed_key, out_word.removed_key);
                    errors++;
                end
                if (out_word.status !== exp_w.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, exp_w.status, out_word.status);
                    errors++;
                end
                if (out_word.entry_count !== exp_w.entry_count) begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, exp_w.entry_count, out_word.entry_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_edge_cases();
        // Empty heap: extract and both positional operations.
        send_word(word_of(mhpq_pkg::MODE_EXTRACT, $urandom, 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_DECREASE, mhpq_pkg::KEY_MIN, 6'd0));
        send_word(word_of(mhpq_pkg::MODE_DELETE, $urandom, 6'd63));
        send_word(word_of(mhpq_pkg::MODE_INSERT, mhpq_pkg::KEY_MAX, 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_INSERT, mhpq_pkg::KEY_MIN, 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_INSERT, 32'sd0, 6'd63));
        send_word(word_of(mhpq_pkg::MODE_INSERT, -32'sd1, 6'd0));
        send_word(word_of(mhpq_pkg::MODE_INSERT, 32'sd1, 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_INSERT, 32'sh5555_5555, 6'h2A));
        send_word(word_of(mhpq_pkg::MODE_INSERT, 32'shAAAA_AAAA, 6'h15));
        send_word(word_of(mhpq_pkg::MODE_INSERT, mhpq_pkg::KEY_MAX, 6'($urandom)));
        // Deepest entry climbs until it ties the root; then a decrease to a larger key.
        send_word(word_of(mhpq_pkg::MODE_DECREASE, mhpq_pkg::KEY_MIN, 6'd7));
        send_word(word_of(mhpq_pkg::MODE_DECREASE, mhpq_pkg::KEY_MAX, 6'd1));
        send_word(word_of(mhpq_pkg::MODE_DECREASE, 32'sd5, 6'd8));
        send_word(word_of(mhpq_pkg::MODE_DECREASE, -32'sd1, 6'd63));
        send_word(word_of(mhpq_pkg::MODE_DELETE, $urandom, 6'd0));
        send_word(word_of(mhpq_pkg::MODE_DELETE, $urandom, 6'd6));
        send_word(word_of(mhpq_pkg::MODE_DELETE, $urandom, 6'd3));
        repeat (6) send_word(word_of(mhpq_pkg::MODE_EXTRACT, $urandom, 6'($urandom)));
        wait_for_results();
    endtask

    task automatic test_fill_and_drain();
        // The receiver stops for a long stretch while the heap is being filled.
        hold_off_req = 1'b1;
        tx_steady = 1'b1;
        while (heap_mdl_count < CAPACITY)
            send_word(word_of(mhpq_pkg::MODE_INSERT, rand_key(), 6'($urandom)));
        tx_steady = 1'b0;
        send_word(word_of(mhpq_pkg::MODE_INSERT, rand_key(), 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_INSERT, mhpq_pkg::KEY_MIN, 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_DECREASE, rand_key(), 6'd63));
        send_word(word_of(mhpq_pkg::MODE_DELETE, $urandom, 6'd63));
        send_word(word_of(mhpq_pkg::MODE_INSERT, rand_key(), 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_DELETE, $urandom, rand_position()));
        while (heap_mdl_count > 0)
            send_word(word_of(mhpq_pkg::MODE_EXTRACT, $urandom, 6'($urandom)));
        send_word(word_of(mhpq_pkg::MODE_EXTRACT, $urandom, 6'($urandom)));
        wait_for_results();
    endtask

    task automatic test_random_mix();
        int bias;
        int roll;
        mhpq_pkg::t_mode m;
        for (int phase = 0; phase < 11; phase++) begin
            // Each phase leans toward growth, shrinkage or balance.
            bias = $urandom_range(2);
            tx_steady = ($urandom_range(99) < 20);
            rx_steady = ($urandom_range(99) < 20);
            repeat (40) begin
                roll = $urandom_range(99);
                if (bias == 0)
                    m = (roll < 65) ? mhpq_pkg::MODE_INSERT :
                        (roll < 80) ? mhpq_pkg::MODE_EXTRACT :
                        (roll < 92) ? mhpq_pkg::MODE_DECREASE : mhpq_pkg::MODE_DELETE;
                else if (bias == 1)
                    m = (roll < 20) ? mhpq_pkg::MODE_INSERT :
                        (roll < 70) ? mhpq_pkg::MODE_EXTRACT :
                        (roll < 85) ? mhpq_pkg::MODE_DECREASE : mhpq_pkg::MODE_DELETE;
                else
                    m = (roll < 40) ? mhpq_pkg::MODE_INSERT :
                        (roll < 65) ? mhpq_pkg::MODE_EXTRACT :
                        (roll < 85) ? mhpq_pkg::MODE_DECREASE : mhpq_pkg::MODE_DELETE;
                send_word(word_of(m, rand_key(), rand_position()));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_for_results();
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        errors = 0;
        words_sent = 0;
        results_checked = 0;
        heap_mdl_count = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        hold_off_req = 1'b0;
        for (int i = 0; i < 4; i++) begin
            mode_seen[i] = 0;
            status_seen[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_fill_and_drain();
        test_random_mix();

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d words (insert %0d, extract %0d, decrease %0d, delete %0d), checked %0d.",
                 words_sent, mode_seen[mhpq_pkg::MODE_INSERT],
                 mode_seen[mhpq_pkg::MODE_EXTRACT], mode_seen[mhpq_pkg::MODE_DECREASE],
                 mode_seen[mhpq_pkg::MODE_DELETE], results_checked);
        $display("Full drops %0d, empty extracts %0d, bad positions %0d.",
                 status_seen[mhpq_pkg::ST_FULL], status_seen[mhpq_pkg::ST_EMPTY],
                 status_seen[mhpq_pkg::ST_RANGE]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_min_heap_priority_queue OK");
        end else begin
            $display("tb_min_heap_priority_queue NOT OK");
        end
        $finish;
    end

endmodule
